// ===== rtl/core/tvs_pkg.sv =====
`default_nettype none

package tvs_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int VALUE_BYTES = 128;
    localparam int SLOT_WORDS  = (VALUE_BYTES + 3) / 4;
    localparam int MEM_DEPTH   = SLOT_COUNT * SLOT_WORDS;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WOFF_W = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int WIDX_W = $clog2(SLOT_WORDS + 1);
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] tag;
        logic [7:0]  value_size;
        logic [7:0]  read_limit;
        logic [31:0] data_word;
        logic        last_word;
    } req_word_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  found_size;
        logic [31:0] data_word_res;
        logic [2:0]  byte_count;
        logic        last;
    } rsp_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET_RD,
        S_GET_DATA
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tvs_ram.sv =====
`default_nettype none

module tvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tagged_value_store.sv =====
`default_nettype none

// Key/value table of 16 slots, each with a 32-bit tag and up to 128 value bytes,
// empty after reset. Get, delete, unused opcodes and store words are accepted at
// one request word per cycle while responses are taken; a get that returns data
// streams its words, each read from the registered value RAM in S_GET_RD and then
// loaded in S_GET_DATA, and takes no new request until its last word is loaded. A
// store value arrives as a run of request words and only the final one gives a
// response. Gets and deletes may be interleaved inside an open store run.

module tagged_value_store (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire tvs_pkg::req_word_t   req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output tvs_pkg::rsp_word_t        rsp
);

    tvs_pkg::state_t state_reg, state_next;

    logic                         used_reg [tvs_pkg::SLOT_COUNT];
    logic                         used_next [tvs_pkg::SLOT_COUNT];
    logic [31:0]                  tag_reg [tvs_pkg::SLOT_COUNT];
    logic [31:0]                  tag_next [tvs_pkg::SLOT_COUNT];
    logic [7:0]                   size_reg [tvs_pkg::SLOT_COUNT];
    logic [7:0]                   size_next [tvs_pkg::SLOT_COUNT];

    logic [tvs_pkg::SLOT_W-1:0]   st_slot_reg, st_slot_next;
    logic [tvs_pkg::WIDX_W-1:0]   st_idx_reg, st_idx_next;
    logic                         st_rej_reg, st_rej_next;

    logic [tvs_pkg::SLOT_W-1:0]   get_slot_reg, get_slot_next;
    logic [tvs_pkg::WOFF_W-1:0]   get_widx_reg, get_widx_next;
    logic [7:0]                   get_rem_reg, get_rem_next;
    logic [7:0]                   get_size_reg, get_size_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    tvs_pkg::rsp_word_t           rsp_reg, rsp_next;

    logic                         match_hit;
    logic [tvs_pkg::SLOT_W-1:0]   match_slot;
    logic                         free_hit;
    logic [tvs_pkg::SLOT_W-1:0]   free_slot;

    logic                         ram_wr_en;
    logic [tvs_pkg::ADDR_W-1:0]   ram_wr_addr;
    logic                         ram_rd_en;
    logic [tvs_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [31:0]                  ram_rd_data;

    logic                         out_free;
    logic                         accept;
    logic                         first;
    logic                         rej_cur;
    logic [tvs_pkg::SLOT_W-1:0]   slot_cur;
    logic [tvs_pkg::WIDX_W-1:0]   idx_inc;
    logic                         bad;
    logic [7:0]                   n_bytes;
    logic [2:0]                   cnt;
    logic [31:0]                  masked;

    tvs_ram #(
        .WIDTH (32),
        .DEPTH (tvs_pkg::MEM_DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (req.data_word),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // first used slot with matching tag, first free slot
    always_comb
    begin
        match_hit  = 1'b0;
        match_slot = '0;
        free_hit   = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < tvs_pkg::SLOT_COUNT; i++)
        begin
            if (!match_hit && used_reg[i] && tag_reg[i] == req.tag)
            begin
                match_hit  = 1'b1;
                match_slot = tvs_pkg::SLOT_W'(i);
            end
            if (!free_hit && !used_reg[i])
            begin
                free_hit  = 1'b1;
                free_slot = tvs_pkg::SLOT_W'(i);
            end
        end
    end

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == tvs_pkg::S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // store run bookkeeping
    always_comb
    begin
        first    = (st_idx_reg == '0);
        rej_cur  = first ? ((int'(req.value_size) > tvs_pkg::VALUE_BYTES)
                            || !(match_hit || free_hit))
                         : st_rej_reg;
        slot_cur = first ? (match_hit ? match_slot : (free_hit ? free_slot : '0))
                         : st_slot_reg;
        idx_inc  = (int'(st_idx_reg) < tvs_pkg::SLOT_WORDS) ? st_idx_reg + 1'b1
                                                            : st_idx_reg;
        bad      = rej_cur || (int'(req.value_size) > tvs_pkg::VALUE_BYTES)
                   || (int'(req.value_size) > 4 * int'(idx_inc));
        n_bytes  = (size_reg[match_slot] < req.read_limit) ? size_reg[match_slot]
                                                           : req.read_limit;
    end

    // outgoing get word
    always_comb
    begin
        cnt = (get_rem_reg >= 8'd4) ? 3'd4 : get_rem_reg[2:0];
        unique case (cnt)
            3'd1:    masked = {24'd0, ram_rd_data[7:0]};
            3'd2:    masked = {16'd0, ram_rd_data[15:0]};
            3'd3:    masked = {8'd0, ram_rd_data[23:0]};
            default: masked = ram_rd_data;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        st_slot_next   = st_slot_reg;
        st_idx_next    = st_idx_reg;
        st_rej_next    = st_rej_reg;
        get_slot_next  = get_slot_reg;
        get_widx_next  = get_widx_reg;
        get_rem_next   = get_rem_reg;
        get_size_next  = get_size_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = tvs_pkg::ADDR_W'(slot_cur) * tvs_pkg::ADDR_W'(tvs_pkg::SLOT_WORDS)
                         + tvs_pkg::ADDR_W'(st_idx_reg);
        ram_rd_en      = 1'b0;
        ram_rd_addr    = tvs_pkg::ADDR_W'(get_slot_reg)
                         * tvs_pkg::ADDR_W'(tvs_pkg::SLOT_WORDS)
                         + tvs_pkg::ADDR_W'(get_widx_reg);

        unique case (state_reg)
            tvs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                    rsp_next.last = 1'b1;
                    priority if (req.opcode == tvs_pkg::OP_GET)
                    begin
                        if (!match_hit)
                        begin
                            rsp_valid_next = 1'b1;
                        end
                        else if (n_bytes == 8'd0)
                        begin
                            rsp_next.found_size = size_reg[match_slot];
                            rsp_valid_next      = 1'b1;
                        end
                        else
                        begin
                            get_slot_next = match_slot;
                            get_widx_next = '0;
                            get_rem_next  = n_bytes;
                            get_size_next = size_reg[match_slot];
                            state_next    = tvs_pkg::S_GET_RD;
                        end
                    end
                    else if (req.opcode == tvs_pkg::OP_STORE)
                    begin
                        ram_wr_en = (int'(st_idx_reg) < tvs_pkg::SLOT_WORDS) && !rej_cur;
                        if (req.last_word)
                        begin
                            if (!bad)
                            begin
                                used_next[slot_cur] = 1'b1;
                                tag_next[slot_cur]  = req.tag;
                                size_next[slot_cur] = req.value_size;
                            end
                            st_slot_next   = slot_cur;
                            st_idx_next    = '0;
                            st_rej_next    = 1'b0;
                            rsp_next.status = bad;
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            st_slot_next = slot_cur;
                            st_idx_next  = idx_inc;
                            st_rej_next  = rej_cur;
                        end
                    end
                    else
                    begin
                        if (req.opcode == tvs_pkg::OP_DELETE && match_hit)
                        begin
                            used_next[match_slot] = 1'b0;
                            tag_next[match_slot]  = '0;
                            size_next[match_slot] = '0;
                        end
                        rsp_valid_next = 1'b1;
                    end
                end
            end

            tvs_pkg::S_GET_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = tvs_pkg::S_GET_DATA;
            end

            tvs_pkg::S_GET_DATA:
            begin
                if (out_free)
                begin
                    rsp_next.status        = 1'b0;
                    rsp_next.found_size    = get_size_reg;
                    rsp_next.data_word_res = masked;
                    rsp_next.byte_count    = cnt;
                    rsp_next.last          = (get_rem_reg <= 8'd4);
                    rsp_valid_next         = 1'b1;
                    if (get_rem_reg <= 8'd4)
                    begin
                        state_next = tvs_pkg::S_IDLE;
                    end
                    else
                    begin
                        get_rem_next  = get_rem_reg - 8'd4;
                        get_widx_next = get_widx_reg + 1'b1;
                        state_next    = tvs_pkg::S_GET_RD;
                    end
                end
            end

            default:
            begin
                state_next = tvs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvs_pkg::S_IDLE;
            st_idx_reg    <= '0;
            st_rej_reg    <= 1'b0;
            st_slot_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < tvs_pkg::SLOT_COUNT; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            st_idx_reg    <= st_idx_next;
            st_rej_reg    <= st_rej_next;
            st_slot_reg   <= st_slot_next;
            rsp_valid_reg <= rsp_valid_next;
            used_reg      <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        size_reg     <= size_next;
        get_slot_reg <= get_slot_next;
        get_widx_reg <= get_widx_next;
        get_rem_reg  <= get_rem_next;
        get_size_reg <= get_size_next;
        rsp_reg      <= rsp_next;
    end

endmodule

`default_nettype wire
